[rtl/fil_pkg.sv]
// ----------------------------------------------------------------------------
// fil_pkg
// Types and codes shared by the front insert link list controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package fil_pkg;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_KILL   = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] link_id;
    logic [7:0] link_index;
  } fil_in_t;

  typedef struct packed {
    logic       changed;
    logic [3:0] live_count;
  } fil_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } fil_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic apply;
  } fil_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;
  } fil_status_t;

endpackage

[rtl/fil_ctrl.sv]
// ----------------------------------------------------------------------------
// fil_ctrl
// Sequencer: takes a request, steps the datapath through the match and
// apply steps and raises the result strobe.
// ----------------------------------------------------------------------------
module fil_ctrl import fil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output fil_cmd_t    cmd,
  input  fil_status_t status,
  output logic        out_valid
);

  fil_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_MATCH: cmd.match = 1'b1;
      ST_APPLY: begin
        cmd.apply     = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign out_valid = out_valid_r;

  a_apply_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid)
    else $error("apply step did not produce a result strobe");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_load_then_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.match ##1 (cmd.apply && !$isunknown(status.hit)))
    else $error("request did not step through match and apply");

endmodule

[rtl/fil_datapath.sv]
// ----------------------------------------------------------------------------
// fil_datapath
// Slot table with parallel match across all slots, front insertion on
// create and gap closing on kill, plus the live entry counter.
// ----------------------------------------------------------------------------
module fil_datapath import fil_pkg::*; #(
  parameter int LINK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fil_cmd_t    cmd,
  input  fil_in_t     in_data,
  output fil_status_t status,
  output fil_out_t    out_data
);

  localparam int CNT_W = $clog2(LINK_SLOTS + 1);

  logic [LINK_SLOTS-1:0] alive_r, alive_nxt;
  logic [7:0]            id_r  [LINK_SLOTS];
  logic [7:0]            id_nxt[LINK_SLOTS];
  logic [7:0]            ix_r  [LINK_SLOTS];
  logic [7:0]            ix_nxt[LINK_SLOTS];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LINK_SLOTS-1:0] match_r;
  logic [LINK_SLOTS-1:0] at_or_after;
  fil_in_t               req_r;
  fil_out_t              out_r;
  logic                  hit;
  logic                  changed;

  assign hit = |match_r;

  // Slots at or behind the first matching slot take part in the gap close.
  always_comb begin
    for (int k = 0; k < LINK_SLOTS; k++) begin
      at_or_after[k] = |(match_r << (LINK_SLOTS - 1 - k));
    end
  end

  always_comb begin
    alive_nxt = alive_r;
    cnt_nxt   = cnt_r;
    changed   = 1'b0;
    for (int k = 0; k < LINK_SLOTS; k++) begin
      id_nxt[k] = id_r[k];
      ix_nxt[k] = ix_r[k];
    end
    if (req_r.opcode == OP_CREATE) begin
      if (!hit) begin
        changed   = 1'b1;
        alive_nxt = (alive_r << 1) | LINK_SLOTS'(1);
        for (int k = 1; k < LINK_SLOTS; k++) begin
          id_nxt[k] = id_r[k-1];
          ix_nxt[k] = ix_r[k-1];
        end
        id_nxt[0] = req_r.link_id;
        ix_nxt[0] = req_r.link_index;
        if (cnt_r != CNT_W'(LINK_SLOTS)) cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (hit) begin
        changed   = 1'b1;
        alive_nxt = (alive_r & ~at_or_after) | ((alive_r >> 1) & at_or_after);
        for (int k = 0; k < LINK_SLOTS - 1; k++) begin
          if (at_or_after[k]) begin
            id_nxt[k] = id_r[k+1];
            ix_nxt[k] = ix_r[k+1];
          end
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.apply) begin
      alive_r <= alive_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.match) begin
      for (int k = 0; k < LINK_SLOTS; k++) begin
        match_r[k] <= alive_r[k] && (id_r[k] == req_r.link_id) &&
                      (ix_r[k] == req_r.link_index);
      end
    end
    if (cmd.apply) begin
      for (int k = 0; k < LINK_SLOTS; k++) begin
        id_r[k] <= id_nxt[k];
        ix_r[k] <= ix_nxt[k];
      end
      out_r.changed    <= changed;
      out_r.live_count <= 4'(cnt_nxt);
    end
  end

  assign status.hit = hit;
  assign out_data   = out_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(alive_r) == int'(cnt_r))
    else $error("live counter disagrees with alive flags");

  a_packed_front: assert property (@(posedge clk) disable iff (!rst_n)
    ((alive_r + LINK_SLOTS'(1)) & alive_r) == '0)
    else $error("live entries are not packed at the front");

  a_kill_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && req_r.opcode == OP_KILL && hit) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("kill of a matching entry did not remove exactly one");

endmodule

[rtl/front_insert_link_list.sv]
// ----------------------------------------------------------------------------
// front_insert_link_list
// Ordered link table with front insertion on create and gap closing on kill.
// ----------------------------------------------------------------------------
// Timing: a request accepted in idle moves to the match state, where all slots
// are compared in parallel and the match is registered, then to the apply
// state, which updates the table and registers the result and its strobe.
// Throughput: a new request is taken only once the controller is back in idle;
// busy is high while a request is in the match and apply states.
// Reset: synchronous; every slot is marked dead and the live count is zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
module front_insert_link_list import fil_pkg::*; #(
  parameter int LINK_SLOTS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fil_in_t  in_data,
  output logic     out_valid,
  output fil_out_t out_data
);

  fil_cmd_t    cmd;
  fil_status_t status;

  fil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid)
  );

  fil_datapath #(
    .LINK_SLOTS (LINK_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[sim/front_insert_link_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_insert_link_list_test
// Self-checking bench for the front insert link list. A queue of link
// commands, directed first and then random, feeds a driver that pulses start
// with random idle gaps. A monitor keeps a shadow copy of the link table,
// predicts the change flag and live count for each accepted request, and
// compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module front_insert_link_list_test;
  import fil_pkg::*;

  localparam int LINK_SLOTS    = 8;
  localparam int POOL_SIZE     = 12;
  localparam int RANDOM_ITEMS  = 1530;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    fil_in_t     req;
    int unsigned idle_pct;
    bit          drain;
  } link_request_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  fil_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  fil_out_t out_data;

  link_request_t pending_requests[$];
  fil_out_t      expected_status[$];

  // Shadow copy of the link table.
  bit       tbl_alive [LINK_SLOTS];
  bit [7:0] tbl_id    [LINK_SLOTS];
  bit [7:0] tbl_index [LINK_SLOTS];

  bit [7:0] pool_id    [POOL_SIZE];
  bit [7:0] pool_index [POOL_SIZE];

  int accepted_total = 0;
  int taken_total    = 0;
  int stall_cycles   = 0;
  int error_count    = 0;

  front_insert_link_list #(
    .LINK_SLOTS(LINK_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  function automatic fil_out_t apply_link_command(input fil_in_t req);
    fil_out_t res;
    int       hit;
    int       live;
    hit = -1;
    live = 0;
    res = '0;
    for (int s = 0; s < LINK_SLOTS; s++) begin
      if (hit < 0 && tbl_alive[s] && tbl_id[s] == req.link_id &&
          tbl_index[s] == req.link_index) begin
        hit = s;
      end
    end
    if (req.opcode == OP_CREATE) begin
      if (hit < 0) begin
        for (int s = LINK_SLOTS - 1; s > 0; s--) begin
          tbl_alive[s] = tbl_alive[s - 1];
          tbl_id[s]    = tbl_id[s - 1];
          tbl_index[s] = tbl_index[s - 1];
        end
        tbl_alive[0] = 1'b1;
        tbl_id[0]    = req.link_id;
        tbl_index[0] = req.link_index;
        res.changed  = 1'b1;
      end
    end else if (hit >= 0) begin
      // Close the gap left by the killed entry; the last slot may itself be hit.
      for (int s = hit; s < LINK_SLOTS - 1; s++) begin
        tbl_alive[s] = tbl_alive[s + 1];
        tbl_id[s]    = tbl_id[s + 1];
        tbl_index[s] = tbl_index[s + 1];
      end
      tbl_alive[LINK_SLOTS - 1] = 1'b0;
      res.changed = 1'b1;
    end
    for (int s = 0; s < LINK_SLOTS; s++) begin
      if (tbl_alive[s]) live++;
    end
    res.live_count = 4'(live);
    return res;
  endfunction

  task automatic push_request(input logic op, input logic [7:0] id,
                              input logic [7:0] index, input int unsigned pct,
                              input bit drain);
    link_request_t r;
    r.req.opcode     = op;
    r.req.link_id    = id;
    r.req.link_index = index;
    r.idle_pct       = pct;
    r.drain          = drain;
    pending_requests.push_back(r);
  endtask

  // Driver: a request stays on the bus until the edge that accepts it.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && accepted_total == taken_total)) begin
      if (start) begin
        void'(pending_requests.pop_front());
        taken_total++;
      end
      if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else if (pending_requests[0].drain && expected_status.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < pending_requests[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_data <= pending_requests[0].req;
      end
    end
  end

  // Monitor: check results first, then record the newly accepted request.
  always @(posedge clk) begin
    fil_out_t want;
    bit       progress;
    progress = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_status.size() == 0) begin
          flag_error($sformatf("result with nothing pending: changed=%0d live=%0d",
                               out_data.changed, out_data.live_count));
        end else begin
          want = expected_status.pop_front();
          if (out_data.changed !== want.changed) begin
            flag_error($sformatf("changed got %0d, expected %0d",
                                 out_data.changed, want.changed));
          end
          if (out_data.live_count !== want.live_count) begin
            flag_error($sformatf("live_count got %0d, expected %0d",
                                 out_data.live_count, want.live_count));
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        expected_status.push_back(apply_link_command(in_data));
        accepted_total <= accepted_total + 1;
      end
      stall_cycles <= progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int          total_items;
    int          k;
    int unsigned pct;
    int unsigned create_pct;
    bit          drain;
    logic        op;
    logic [7:0]  id;
    logic [7:0]  index;

    for (int s = 0; s < LINK_SLOTS; s++) begin
      tbl_alive[s] = 1'b0;
      tbl_id[s]    = '0;
      tbl_index[s] = '0;
    end

    // Directed: empty kill, fill past capacity, duplicate, kill in last slot.
    push_request(OP_KILL,   8'h00, 8'h00, 37, 1'b0);
    push_request(OP_CREATE, 8'h00, 8'h00, 37, 1'b0);
    push_request(OP_CREATE, 8'hFF, 8'hFF, 37, 1'b0);
    push_request(OP_CREATE, 8'h00, 8'h00, 37, 1'b0);
    for (int n = 1; n <= 6; n++) begin
      push_request(OP_CREATE, 8'(n), 8'hA5 ^ 8'(n), 37, 1'b0);
    end
    push_request(OP_CREATE, 8'h80, 8'h7F, 37, 1'b0);
    push_request(OP_CREATE, 8'h80, 8'h7F, 37, 1'b0);
    push_request(OP_KILL,   8'h00, 8'h00, 37, 1'b0);
    push_request(OP_KILL,   8'hFF, 8'hFF, 37, 1'b0);
    push_request(OP_CREATE, 8'hFF, 8'h00, 37, 1'b1);
    push_request(OP_CREATE, 8'h00, 8'hFF, 37, 1'b0);
    push_request(OP_KILL,   8'h03, 8'hA6, 37, 1'b0);
    push_request(OP_KILL,   8'h03, 8'hA5, 37, 1'b0);
    push_request(OP_KILL,   8'h04, 8'h00, 37, 1'b0);
    push_request(OP_KILL,   8'h00, 8'hFF, 37, 1'b0);
    push_request(OP_KILL,   8'h00, 8'hFF, 37, 1'b0);

    // Keys that recur so that kills hit and creates collide.
    pool_id[0]    = 8'h00;
    pool_index[0] = 8'h00;
    pool_id[1]    = 8'hFF;
    pool_index[1] = 8'hFF;
    for (int p = 2; p < POOL_SIZE; p++) begin
      pool_id[p]    = ($urandom_range(2) == 0) ? pool_id[p - 1] : 8'($urandom_range(255));
      pool_index[p] = 8'($urandom_range(255));
    end

    create_pct = 60;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = n / (RANDOM_ITEMS / 3);
      pct = (k == 0) ? 37 : (k == 1) ? 74 : 0;
      drain = (n % (RANDOM_ITEMS / 3) == 0) || ($urandom_range(99) == 0);
      if (n % 60 == 0) create_pct = $urandom_range(35, 80);
      if ($urandom_range(99) < 25) begin
        op    = 1'($urandom_range(1));
        id    = 8'($urandom_range(255));
        index = 8'($urandom_range(255));
      end else begin
        k     = $urandom_range(POOL_SIZE - 1);
        op    = ($urandom_range(99) < create_pct) ? OP_CREATE : OP_KILL;
        id    = pool_id[k];
        index = pool_index[k];
      end
      push_request(op, id, index, pct, drain);
    end
    total_items = pending_requests.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk);
    while (accepted_total != total_items || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0 && expected_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
